[src/iss_pkg.sv]
// Shared command codes, status codes and cell control type for the sequence store.
package iss_pkg;

  // Command codes
  localparam logic [2:0] CMD_GET       = 3'd0;
  localparam logic [2:0] CMD_SET       = 3'd1;
  localparam logic [2:0] CMD_INS_FIRST = 3'd2;
  localparam logic [2:0] CMD_DEL_FIRST = 3'd3;
  localparam logic [2:0] CMD_INS_LAST  = 3'd4;
  localparam logic [2:0] CMD_DEL_LAST  = 3'd5;
  localparam logic [2:0] CMD_INS_AT    = 3'd6;
  localparam logic [2:0] CMD_DEL_AT    = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Port widths fixed by the interface
  localparam int CmdWidth   = 3;
  localparam int PosWidth   = 6;
  localparam int ValueWidth = 32;
  localparam int CountWidth = 7;

  // Control broadcast to every cell; the base slot travels beside it
  typedef struct packed {
    logic load;   // cell at base takes the new value
    logic up;     // cells above base take their lower neighbor
    logic down;   // cells at and above base take their upper neighbor
  } cell_ctl_t;

endpackage

[src/indexed_sequence_store.sv]
// Top level of the indexed sequence store: control, cell row and result register.
//
// A fixed-capacity sequence of CAPACITY elements held in a row of cells, one
// element per cell, with a live count. Each command (get, set, insert or
// delete at the front, back or an index) is accepted on start, as busy stays
// low, so a new item may be issued on every clock. Every cell can load its
// neighbor in the same cycle, so a whole-row shift for an insert or delete
// completes at the accepting edge. Exactly one result follows each item, on
// the out_ ports in the cycle after acceptance, marked by out_valid;
// there is no back-pressure, so the receiver must take it then. Reset clears
// every element and the count, with no clearing pass.
module indexed_sequence_store #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic        [iss_pkg::CmdWidth-1:0]    in_command,
  input  logic        [iss_pkg::PosWidth-1:0]    in_position,
  input  logic signed [iss_pkg::ValueWidth-1:0]  in_item_value,
  output logic                                   out_valid,
  output logic signed [iss_pkg::ValueWidth-1:0]  out_read_value,
  output logic        [1:0]                      out_status,
  output logic        [iss_pkg::CountWidth-1:0]  out_element_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  accept;
  iss_pkg::cell_ctl_t    ctl;
  logic [IW-1:0]         base;
  logic                  rd_en;
  logic [IW-1:0]         rd_idx;
  logic [1:0]            status;
  logic [CW-1:0]         count_after;
  logic [DATA_WIDTH-1:0] din;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;

  logic                                   valid_r;
  logic signed [iss_pkg::ValueWidth-1:0]  read_value_r;
  logic        [1:0]                      status_r;
  logic        [iss_pkg::CountWidth-1:0]  count_r;

  // Commands finish on acceptance: never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign din    = DATA_WIDTH'($unsigned(in_item_value));

  iss_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_command),
    .position    (in_position),
    .ctl         (ctl),
    .base        (base),
    .rd_en       (rd_en),
    .rd_idx      (rd_idx),
    .status      (status),
    .count_after (count_after)
  );

  // Row of cells; the ends see zero from outside
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_q;
    logic [DATA_WIDTH-1:0] upper_q;

    if (g == 0) begin : g_lo_end
      assign lower_q = '0;
    end else begin : g_lo
      assign lower_q = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_hi_end
      assign upper_q = '0;
    end else begin : g_hi
      assign upper_q = cell_q[g+1];
    end

    iss_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .IDX        (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .base    (base),
      .din     (din),
      .lower_q (lower_q),
      .upper_q (upper_q),
      .q       (cell_q[g])
    );
  end

  // Read select across the row
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (rd_idx == IW'(k)) rd_data = rd_data | cell_q[k];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_r <= rd_en ? iss_pkg::ValueWidth'(rd_data) : '0;
      status_r     <= status;
      count_r      <= iss_pkg::CountWidth'(count_after);
    end
  end

  assign out_valid         = valid_r;
  assign out_read_value    = read_value_r;
  assign out_status        = status_r;
  assign out_element_count = count_r;

endmodule

[src/iss_cell.sv]
// One storage slot of the sequence store, shifting with its neighbors.
module iss_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iss_pkg::cell_ctl_t    ctl,
  input  logic [IW-1:0]         base,
  input  logic [DATA_WIDTH-1:0] din,
  input  logic [DATA_WIDTH-1:0] lower_q,
  input  logic [DATA_WIDTH-1:0] upper_q,
  output logic [DATA_WIDTH-1:0] q
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  at_base;
  logic                  above_base;

  assign at_base    = (base == IW'(IDX));
  assign above_base = (IW'(IDX) > base);

  // Slot update: new value, shift up, shift down or hold
  always_comb begin
    data_nxt = data_r;
    priority if (ctl.load && at_base) begin
      data_nxt = din;
    end else if (ctl.up && above_base) begin
      data_nxt = lower_q;
    end else if (ctl.down && (at_base || above_base)) begin
      data_nxt = upper_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;

endmodule

[src/iss_ctrl.sv]
// Command decode and live element count for the sequence store.
module iss_ctrl #(
  parameter int CAPACITY = 64,
  parameter int IW       = 6,
  parameter int CW       = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [iss_pkg::CmdWidth-1:0]    command,
  input  logic [iss_pkg::PosWidth-1:0]    position,
  output iss_pkg::cell_ctl_t              ctl,
  output logic [IW-1:0]                   base,
  output logic                            rd_en,
  output logic [IW-1:0]                   rd_idx,
  output logic [1:0]                      status,
  output logic [CW-1:0]                   count_after
);

  // Compare width covering both the position port and the count
  localparam int WW = ((CW > iss_pkg::PosWidth) ? CW : iss_pkg::PosWidth) + 1;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [WW-1:0]     posw;
  logic [WW-1:0]     cntw;
  logic [WW-1:0]     capw;
  logic [WW-1:0]     cnt_new;
  logic              full;
  logic              empty;
  logic              pos_in_cap;
  logic              pos_in_cnt;
  iss_pkg::cell_ctl_t ctl_raw;

  assign posw       = WW'(position);
  assign cntw       = WW'(count_r);
  assign capw       = WW'(CAPACITY);
  assign full       = (cntw >= capw);
  assign empty      = (count_r == '0);
  assign pos_in_cap = (posw < capw);
  assign pos_in_cnt = (posw < cntw);

  // Decode one command against the current count
  always_comb begin
    ctl_raw = '0;
    base    = IW'(posw);
    rd_en   = 1'b0;
    rd_idx  = IW'(posw);
    status  = iss_pkg::ST_OK;
    cnt_new = cntw;
    unique case (command)
      iss_pkg::CMD_GET: begin
        if (pos_in_cnt) rd_en = 1'b1;
        else status = iss_pkg::ST_BAD_INDEX;
      end
      iss_pkg::CMD_SET: begin
        if (pos_in_cap) begin
          ctl_raw.load = 1'b1;
          if (!pos_in_cnt) cnt_new = posw + WW'(1);
        end else begin
          status = iss_pkg::ST_BAD_INDEX;
        end
      end
      iss_pkg::CMD_INS_FIRST: begin
        if (full) begin
          status = iss_pkg::ST_FULL;
        end else begin
          ctl_raw.load = 1'b1;
          ctl_raw.up   = 1'b1;
          base         = '0;
          cnt_new      = cntw + WW'(1);
        end
      end
      iss_pkg::CMD_DEL_FIRST: begin
        if (empty) begin
          status = iss_pkg::ST_EMPTY;
        end else begin
          rd_en        = 1'b1;
          rd_idx       = '0;
          ctl_raw.down = 1'b1;
          base         = '0;
          cnt_new      = cntw - WW'(1);
        end
      end
      iss_pkg::CMD_INS_LAST: begin
        if (full) begin
          status = iss_pkg::ST_FULL;
        end else begin
          ctl_raw.load = 1'b1;
          base         = IW'(cntw);
          cnt_new      = cntw + WW'(1);
        end
      end
      iss_pkg::CMD_DEL_LAST: begin
        if (empty) begin
          status = iss_pkg::ST_EMPTY;
        end else begin
          // top element shifts in the cleared slot above it
          rd_en        = 1'b1;
          rd_idx       = IW'(cntw - WW'(1));
          ctl_raw.down = 1'b1;
          base         = IW'(cntw - WW'(1));
          cnt_new      = cntw - WW'(1);
        end
      end
      iss_pkg::CMD_INS_AT: begin
        if (!pos_in_cap) begin
          status = iss_pkg::ST_BAD_INDEX;
        end else if (!pos_in_cnt) begin
          ctl_raw.load = 1'b1;
          cnt_new      = posw + WW'(1);
        end else if (full) begin
          status = iss_pkg::ST_FULL;
        end else begin
          ctl_raw.load = 1'b1;
          ctl_raw.up   = 1'b1;
          cnt_new      = cntw + WW'(1);
        end
      end
      iss_pkg::CMD_DEL_AT: begin
        if (empty) begin
          status = iss_pkg::ST_EMPTY;
        end else if (!pos_in_cnt) begin
          status = iss_pkg::ST_BAD_INDEX;
        end else begin
          rd_en        = 1'b1;
          ctl_raw.down = 1'b1;
          cnt_new      = cntw - WW'(1);
        end
      end
      default: begin
        status = iss_pkg::ST_OK;
      end
    endcase
  end

  // Cells move only on an accepted item
  assign ctl         = accept ? ctl_raw : '0;
  assign count_after = CW'(cnt_new);
  assign count_nxt   = accept ? CW'(cnt_new) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

[bench/indexed_sequence_store_test.sv]
// Self-checking testbench for the indexed sequence store: directed table, then random traffic.
`timescale 1ns / 1ps

module indexed_sequence_store_test;

  localparam int Capacity   = 64;
  localparam int DataWidth  = 32;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 340;

  // One result as the store reports it
  typedef struct packed {
    logic signed [iss_pkg::ValueWidth-1:0] read_value;
    logic [1:0]                            status;
    logic [iss_pkg::CountWidth-1:0]        count;
  } seq_result_t;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [iss_pkg::CmdWidth-1:0]          cmd;
    logic [iss_pkg::PosWidth-1:0]          pos;
    logic signed [iss_pkg::ValueWidth-1:0] value;
    logic                                  typed;
    seq_result_t                           want;
  } directed_row_t;

  typedef enum {FILLING, DRAINING, MIXING} traffic_mode_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  start;
  logic                                  busy;
  logic [iss_pkg::CmdWidth-1:0]          in_command;
  logic [iss_pkg::PosWidth-1:0]          in_position;
  logic signed [iss_pkg::ValueWidth-1:0] in_item_value;
  logic                                  out_valid;
  logic signed [iss_pkg::ValueWidth-1:0] out_read_value;
  logic [1:0]                            out_status;
  logic [iss_pkg::CountWidth-1:0]        out_element_count;

  // Shadow copy of the store
  logic signed [iss_pkg::ValueWidth-1:0] shadow_cells [Capacity];
  int                                    shadow_count;

  seq_result_t   pending_results [$];
  seq_result_t   oldest_result;
  seq_result_t   predicted_result;
  directed_row_t directed_rows [$];
  logic          cur_typed;
  seq_result_t   cur_expected;
  int            mismatch_count;
  int            cycle_count;
  int            idle_pct;

  indexed_sequence_store #(
    .CAPACITY  (Capacity),
    .DATA_WIDTH(DataWidth)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .out_element_count(out_element_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Move slots at and above pos up by one
  function automatic void open_gap(input int pos);
    for (int k = shadow_count; k > pos; k--) shadow_cells[k] = shadow_cells[k-1];
  endfunction

  // Remove slot pos, shift the rest down, clear the vacated top slot
  function automatic logic signed [iss_pkg::ValueWidth-1:0] close_gap(input int pos);
    logic signed [iss_pkg::ValueWidth-1:0] removed;
    removed = shadow_cells[pos];
    for (int k = pos; k + 1 < shadow_count; k++) shadow_cells[k] = shadow_cells[k+1];
    shadow_cells[shadow_count-1] = '0;
    shadow_count--;
    return removed;
  endfunction

  // Write a slot, growing the count when writing at or past the end
  function automatic logic [1:0] write_slot(input int pos, input logic signed [31:0] value);
    if (pos >= Capacity) return iss_pkg::ST_BAD_INDEX;
    shadow_cells[pos] = value;
    if (pos >= shadow_count) shadow_count = pos + 1;
    return iss_pkg::ST_OK;
  endfunction

  // Apply one command to the shadow store and return the result it must produce
  function automatic seq_result_t apply_command(
    input logic [iss_pkg::CmdWidth-1:0]          cmd,
    input logic [iss_pkg::PosWidth-1:0]          pos_bits,
    input logic signed [iss_pkg::ValueWidth-1:0] value
  );
    seq_result_t r;
    int          pos;
    pos          = int'(pos_bits);
    r.read_value = '0;
    r.status     = iss_pkg::ST_OK;
    case (cmd)
      iss_pkg::CMD_GET: begin
        if (pos < shadow_count) r.read_value = shadow_cells[pos];
        else r.status = iss_pkg::ST_BAD_INDEX;
      end
      iss_pkg::CMD_SET: r.status = write_slot(pos, value);
      iss_pkg::CMD_INS_FIRST, iss_pkg::CMD_INS_LAST: begin
        if (shadow_count >= Capacity) begin
          r.status = iss_pkg::ST_FULL;
        end else if (cmd == iss_pkg::CMD_INS_FIRST) begin
          open_gap(0);
          shadow_cells[0] = value;
          shadow_count++;
        end else begin
          shadow_cells[shadow_count] = value;
          shadow_count++;
        end
      end
      iss_pkg::CMD_DEL_FIRST, iss_pkg::CMD_DEL_LAST: begin
        if (shadow_count == 0) r.status = iss_pkg::ST_EMPTY;
        else if (cmd == iss_pkg::CMD_DEL_FIRST) r.read_value = close_gap(0);
        else r.read_value = close_gap(shadow_count - 1);
      end
      iss_pkg::CMD_INS_AT: begin
        if (pos >= Capacity) begin
          r.status = iss_pkg::ST_BAD_INDEX;
        end else if (pos >= shadow_count) begin
          r.status = write_slot(pos, value);
        end else if (shadow_count >= Capacity) begin
          r.status = iss_pkg::ST_FULL;
        end else begin
          open_gap(pos);
          shadow_cells[pos] = value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) r.status = iss_pkg::ST_EMPTY;
        else if (pos >= shadow_count) r.status = iss_pkg::ST_BAD_INDEX;
        else r.read_value = close_gap(pos);
      end
    endcase
    r.count = shadow_count[iss_pkg::CountWidth-1:0];
    return r;
  endfunction

  // Present one item at a falling edge and hold it until the block takes it
  task automatic send_item(
    input logic [iss_pkg::CmdWidth-1:0]          cmd,
    input logic [iss_pkg::PosWidth-1:0]          pos,
    input logic signed [iss_pkg::ValueWidth-1:0] value,
    input logic                                  typed,
    input seq_result_t                           want
  );
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_position   <= pos;
    in_item_value <= value;
    cur_typed      = typed;
    cur_expected   = want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random value, with the extremes showing up often
  function automatic logic signed [iss_pkg::ValueWidth-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      3:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // Position mostly inside or just past the live region
  function automatic logic [iss_pkg::PosWidth-1:0] pick_position();
    int p;
    case ($urandom_range(9))
      5, 6:    p = $urandom_range(Capacity - 1);
      7:       p = shadow_count - 1;
      8:       p = shadow_count;
      9:       p = $urandom_range(1) ? 0 : Capacity - 1;
      default: p = $urandom_range(shadow_count);
    endcase
    if (p < 0) p = 0;
    if (p > Capacity - 1) p = Capacity - 1;
    return p[iss_pkg::PosWidth-1:0];
  endfunction

  function automatic logic [iss_pkg::CmdWidth-1:0] pick_command(input traffic_mode_t mode);
    int r;
    logic [iss_pkg::CmdWidth-1:0] deletes [3];
    logic [iss_pkg::CmdWidth-1:0] inserts [3];
    deletes = '{iss_pkg::CMD_DEL_FIRST, iss_pkg::CMD_DEL_LAST, iss_pkg::CMD_DEL_AT};
    inserts = '{iss_pkg::CMD_INS_FIRST, iss_pkg::CMD_INS_LAST, iss_pkg::CMD_INS_AT};
    r = $urandom_range(99);
    if (mode == FILLING) begin
      if (r < 20) return iss_pkg::CMD_INS_LAST;
      if (r < 40) return iss_pkg::CMD_INS_FIRST;
      if (r < 55) return iss_pkg::CMD_INS_AT;
      if (r < 65) return iss_pkg::CMD_SET;
      if (r < 80) return iss_pkg::CMD_GET;
      return deletes[$urandom_range(2)];
    end
    if (mode == DRAINING) begin
      if (r < 20) return iss_pkg::CMD_DEL_LAST;
      if (r < 40) return iss_pkg::CMD_DEL_FIRST;
      if (r < 60) return iss_pkg::CMD_DEL_AT;
      if (r < 75) return iss_pkg::CMD_GET;
      if (r < 85) return iss_pkg::CMD_SET;
      return inserts[$urandom_range(2)];
    end
    return iss_pkg::CmdWidth'($urandom_range(7));
  endfunction

  // Result checking and prediction at every rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_read_value, 32'h0);
        end else begin
          oldest_result = pending_results.pop_front();
          if (out_read_value !== oldest_result.read_value)
            report_mismatch("read_value", out_read_value, oldest_result.read_value);
          if (out_status !== oldest_result.status)
            report_mismatch("status", 32'(out_status), 32'(oldest_result.status));
          if (out_element_count !== oldest_result.count)
            report_mismatch("element_count", 32'(out_element_count),
                            32'(oldest_result.count));
        end
      end
      if (start && !busy) begin
        predicted_result = apply_command(in_command, in_position, in_item_value);
        pending_results.push_back(cur_typed ? cur_expected : predicted_result);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    traffic_mode_t mode;
    logic [iss_pkg::CmdWidth-1:0] cmd;
    int idle_phases [4];

    idle_phases    = '{0, 66, 24, 0};
    mismatch_count = 0;
    cycle_count    = 0;
    idle_pct       = 0;
    cur_typed      = 1'b0;
    cur_expected   = '0;
    shadow_count   = 0;
    for (int k = 0; k < Capacity; k++) shadow_cells[k] = '0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = iss_pkg::CMD_GET;
    in_position   = '0;
    in_item_value = '0;

    // Directed table: cmd, pos, value, typed, {read_value, status, count}
    directed_rows.push_back('{iss_pkg::CMD_GET,       6'd0,  32'h0,        1'b1,
                              '{32'h0,        iss_pkg::ST_BAD_INDEX, 7'd0}});
    directed_rows.push_back('{iss_pkg::CMD_DEL_FIRST, 6'd0,  32'h0,        1'b1,
                              '{32'h0,        iss_pkg::ST_EMPTY,     7'd0}});
    directed_rows.push_back('{iss_pkg::CMD_DEL_LAST,  6'd0,  32'h0,        1'b1,
                              '{32'h0,        iss_pkg::ST_EMPTY,     7'd0}});
    directed_rows.push_back('{iss_pkg::CMD_DEL_AT,    6'd0,  32'h0,        1'b1,
                              '{32'h0,        iss_pkg::ST_EMPTY,     7'd0}});
    directed_rows.push_back('{iss_pkg::CMD_INS_LAST,  6'd9,  32'h7fffffff, 1'b1,
                              '{32'h0,        iss_pkg::ST_OK,        7'd1}});
    directed_rows.push_back('{iss_pkg::CMD_INS_FIRST, 6'd63, 32'h80000000, 1'b1,
                              '{32'h0,        iss_pkg::ST_OK,        7'd2}});
    directed_rows.push_back('{iss_pkg::CMD_GET,       6'd0,  32'h0,        1'b1,
                              '{32'h80000000, iss_pkg::ST_OK,        7'd2}});
    directed_rows.push_back('{iss_pkg::CMD_GET,       6'd1,  32'h0,        1'b1,
                              '{32'h7fffffff, iss_pkg::ST_OK,        7'd2}});
    directed_rows.push_back('{iss_pkg::CMD_GET,       6'd2,  32'h0,        1'b1,
                              '{32'h0,        iss_pkg::ST_BAD_INDEX, 7'd2}});
    directed_rows.push_back('{iss_pkg::CMD_DEL_AT,    6'd5,  32'h0,        1'b1,
                              '{32'h0,        iss_pkg::ST_BAD_INDEX, 7'd2}});
    directed_rows.push_back('{iss_pkg::CMD_INS_AT,    6'd1,  32'h12345678, 1'b0, '0});
    directed_rows.push_back('{iss_pkg::CMD_INS_AT,    6'd10, 32'hffffffff, 1'b0, '0});
    // the gap left by writing past the end reads back as zero
    directed_rows.push_back('{iss_pkg::CMD_GET,       6'd7,  32'h0,        1'b1,
                              '{32'h0,        iss_pkg::ST_OK,        7'd11}});
    directed_rows.push_back('{iss_pkg::CMD_SET,       6'd63, 32'ha5a5a5a5, 1'b1,
                              '{32'h0,        iss_pkg::ST_OK,        7'd64}});
    directed_rows.push_back('{iss_pkg::CMD_INS_FIRST, 6'd0,  32'h1,        1'b1,
                              '{32'h0,        iss_pkg::ST_FULL,      7'd64}});
    directed_rows.push_back('{iss_pkg::CMD_INS_LAST,  6'd0,  32'h2,        1'b1,
                              '{32'h0,        iss_pkg::ST_FULL,      7'd64}});
    directed_rows.push_back('{iss_pkg::CMD_INS_AT,    6'd3,  32'h3,        1'b1,
                              '{32'h0,        iss_pkg::ST_FULL,      7'd64}});
    directed_rows.push_back('{iss_pkg::CMD_INS_AT,    6'd63, 32'h4,        1'b1,
                              '{32'h0,        iss_pkg::ST_FULL,      7'd64}});
    directed_rows.push_back('{iss_pkg::CMD_SET,       6'd0,  32'h0,        1'b0, '0});
    directed_rows.push_back('{iss_pkg::CMD_GET,       6'd63, 32'h0,        1'b1,
                              '{32'ha5a5a5a5, iss_pkg::ST_OK,        7'd64}});
    directed_rows.push_back('{iss_pkg::CMD_DEL_LAST,  6'd0,  32'h0,        1'b1,
                              '{32'ha5a5a5a5, iss_pkg::ST_OK,        7'd63}});
    directed_rows.push_back('{iss_pkg::CMD_DEL_FIRST, 6'd0,  32'h0,        1'b0, '0});
    directed_rows.push_back('{iss_pkg::CMD_DEL_AT,    6'd0,  32'h0,        1'b0, '0});
    directed_rows.push_back('{iss_pkg::CMD_GET,       6'd63, 32'h0,        1'b1,
                              '{32'h0,        iss_pkg::ST_BAD_INDEX, 7'd61}});
    directed_rows.push_back('{iss_pkg::CMD_DEL_AT,    6'd60, 32'h0,        1'b0, '0});

    // Reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].want);

    // Random traffic in phases of different idling
    mode = FILLING;
    foreach (idle_phases[ph]) begin
      // let everything drain before the next phase
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
      @(negedge clk);
      idle_pct = idle_phases[ph];
      for (int n = 0; n < PhaseItems; n++) begin
        if (mode == FILLING && shadow_count >= Capacity) mode = DRAINING;
        else if (mode == DRAINING && shadow_count == 0) mode = FILLING;
        else if ($urandom_range(49) == 0) mode = traffic_mode_t'($urandom_range(2));
        cmd = pick_command(mode);
        send_item(cmd, pick_position(), pick_value(), 1'b0, '0);
      end
    end
    start <= 1'b0;

    // Drain and finish
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
